// ----- rtl/core/stq_pkg.sv -----
// ============================================================================
// stq_pkg: shared types and constants of the sorted timeout queue
// Entry layout, command and result codes, controller states and the
// command and status bundles that join the controller to the datapath.
// ============================================================================
package stq_pkg;

    // Queue geometry.
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // At most this many entries leave the queue on one finished second.
    localparam int MAX_EXPIRE = 16;
    localparam int EXP_W      = $clog2(MAX_EXPIRE + 1);

    // Field widths.
    localparam int CMD_W  = 2;
    localparam int HND_W  = 16;
    localparam int TAG_W  = 32;
    localparam int OFS_W  = 16;
    localparam int SEC_W  = 32;
    localparam int TPS_W  = 7;
    localparam int KIND_W = 2;
    localparam int RCNT_W = 5;

    localparam logic [TPS_W-1:0]  TPS_RESET = 7'd50;
    localparam logic [RCNT_W-1:0] RCNT_MAX  = 5'd31;

    // Input command codes.
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSTALL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_INSTALLED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVED   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EXPIRED   = 2'd3;

    typedef struct packed {
        logic [SEC_W-1:0] deadline;
        logic [HND_W-1:0] handler;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_SCAN,
        ST_REM_SCAN,
        ST_RESP,
        ST_EXPIRE
    } state_t;

    typedef struct packed {
        logic              load;
        logic              scan_clr;
        logic              scan_inc;
        logic              do_insert;
        logic              do_drop;
        logic              exp_inc;
        logic              out_load;
        logic [KIND_W-1:0] out_kind;
        logic              out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             wrap;
        logic             full;
        logic             idx_lt_cnt;
        logic             ins_go;
        logic             match;
        logic             exp_due;
        logic             exp_last;
        logic             out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/stq_datapath.sv -----
// ============================================================================
// stq_datapath: entry store, scan counters, prescaler and result register
// Holds the sorted entries in registers that shift by one place on insert
// and delete, and the single result register toward the output channel.
// ============================================================================
module stq_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wen,
    input  logic [stq_pkg::TPS_W-1:0]    cfg_wdata,
    input  logic [stq_pkg::CMD_W-1:0]    in_cmd,
    input  logic [stq_pkg::HND_W-1:0]    in_handler,
    input  logic [stq_pkg::TAG_W-1:0]    in_tag,
    input  logic [stq_pkg::OFS_W-1:0]    in_offset,
    input  stq_pkg::dp_cmd_t             ctl,
    output stq_pkg::dp_stat_t            stat,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [stq_pkg::KIND_W-1:0]   out_kind,
    output logic [stq_pkg::HND_W-1:0]    out_handler,
    output logic [stq_pkg::TAG_W-1:0]    out_tag,
    output logic [stq_pkg::RCNT_W-1:0]   out_count,
    output logic [stq_pkg::SEC_W-1:0]    out_now,
    output logic                         out_last
);

    localparam int DEPTH = stq_pkg::DEPTH;

    stq_pkg::entry_t               ent_reg [DEPTH];
    stq_pkg::entry_t               up_src  [DEPTH];
    stq_pkg::entry_t               dn_src  [DEPTH];
    stq_pkg::entry_t               new_ent;
    stq_pkg::entry_t               sel_ent;

    logic [stq_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [stq_pkg::CNT_W-1:0]     idx_reg;
    logic [stq_pkg::RCNT_W-1:0]    gone_reg;
    logic [stq_pkg::EXP_W-1:0]     exp_n_reg;
    logic [stq_pkg::TPS_W-1:0]     tps_reg;
    logic [stq_pkg::TPS_W-1:0]     ticks_reg;
    logic [stq_pkg::TPS_W-1:0]     reload;
    logic [stq_pkg::SEC_W-1:0]     sec_reg;
    logic                          wrap_reg;
    logic [stq_pkg::CMD_W-1:0]     cmd_reg;
    logic [stq_pkg::HND_W-1:0]     hnd_reg;
    logic [stq_pkg::TAG_W-1:0]     tag_reg;
    logic [stq_pkg::SEC_W-1:0]     when_reg;

    logic                          out_valid_reg;
    logic [stq_pkg::KIND_W-1:0]    out_kind_reg;
    logic [stq_pkg::HND_W-1:0]     out_hnd_reg;
    logic [stq_pkg::TAG_W-1:0]     out_tag_reg;
    logic [stq_pkg::RCNT_W-1:0]    out_cnt_reg;
    logic [stq_pkg::SEC_W-1:0]     out_now_reg;
    logic                          out_last_reg;

    // Neighbor taps for the one-place shifts.
    for (genvar j = 0; j < DEPTH; j++) begin : g_tap
        if (j == 0) begin : g_first
            assign up_src[j] = ent_reg[j];
        end else begin : g_rest
            assign up_src[j] = ent_reg[j-1];
        end
        if (j == DEPTH - 1) begin : g_last
            assign dn_src[j] = ent_reg[j];
        end else begin : g_inner
            assign dn_src[j] = ent_reg[j+1];
        end
    end

    assign new_ent = '{deadline: when_reg, handler: hnd_reg, tag: tag_reg};
    assign sel_ent = ent_reg[idx_reg[stq_pkg::IDX_W-1:0]];
    assign reload  = (tps_reg == '0) ? stq_pkg::TPS_W'(1) : tps_reg;

    always_ff @(posedge aclk) begin
        for (int j = 0; j < DEPTH; j++) begin
            if (ctl.do_insert) begin
                if (stq_pkg::CNT_W'(j) == idx_reg) begin
                    ent_reg[j] <= new_ent;
                end else if (stq_pkg::CNT_W'(j) > idx_reg) begin
                    ent_reg[j] <= up_src[j];
                end
            end else if (ctl.do_drop) begin
                if (stq_pkg::CNT_W'(j) >= idx_reg) begin
                    ent_reg[j] <= dn_src[j];
                end
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.do_insert) begin
            count_next = count_reg + stq_pkg::CNT_W'(1);
        end else if (ctl.do_drop) begin
            count_next = count_reg - stq_pkg::CNT_W'(1);
        end
    end

    // Control state: counters, prescaler, seconds and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            tps_reg   <= stq_pkg::TPS_RESET;
            ticks_reg <= stq_pkg::TPS_RESET;
            sec_reg   <= '0;
            wrap_reg  <= 1'b0;
            idx_reg   <= '0;
            gone_reg  <= '0;
            exp_n_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (cfg_wen) begin
                tps_reg <= cfg_wdata;
            end
            if (ctl.load) begin
                wrap_reg <= 1'b0;
                if (in_cmd == stq_pkg::CMD_TICK) begin
                    if (ticks_reg > stq_pkg::TPS_W'(1)) begin
                        ticks_reg <= ticks_reg - stq_pkg::TPS_W'(1);
                    end else begin
                        ticks_reg <= ticks_reg + reload - stq_pkg::TPS_W'(1);
                        sec_reg   <= sec_reg + stq_pkg::SEC_W'(1);
                        wrap_reg  <= 1'b1;
                    end
                end
            end
            if (ctl.scan_clr) begin
                idx_reg   <= '0;
                gone_reg  <= '0;
                exp_n_reg <= '0;
            end else begin
                if (ctl.scan_inc) begin
                    idx_reg <= idx_reg + stq_pkg::CNT_W'(1);
                end
                if (ctl.do_drop && gone_reg != stq_pkg::RCNT_MAX) begin
                    gone_reg <= gone_reg + stq_pkg::RCNT_W'(1);
                end
                if (ctl.exp_inc) begin
                    exp_n_reg <= exp_n_reg + stq_pkg::EXP_W'(1);
                end
            end
        end
    end

    // Captured item.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg  <= in_cmd;
            hnd_reg  <= in_handler;
            tag_reg  <= in_tag;
            when_reg <= sec_reg + stq_pkg::SEC_W'(in_offset);
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            out_kind_reg <= ctl.out_kind;
            out_now_reg  <= sec_reg;
            out_last_reg <= ctl.out_last;
            if (ctl.out_kind == stq_pkg::KIND_EXPIRED) begin
                out_hnd_reg <= ent_reg[0].handler;
                out_tag_reg <= ent_reg[0].tag;
            end else begin
                out_hnd_reg <= hnd_reg;
                out_tag_reg <= tag_reg;
            end
            out_cnt_reg <= (ctl.out_kind == stq_pkg::KIND_REMOVED) ? gone_reg : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_handler = out_hnd_reg;
    assign out_tag     = out_tag_reg;
    assign out_count   = out_cnt_reg;
    assign out_now     = out_now_reg;
    assign out_last    = out_last_reg;

    always_comb begin
        stat.cmd        = cmd_reg;
        stat.wrap       = wrap_reg;
        stat.full       = (count_reg == stq_pkg::CNT_W'(DEPTH));
        stat.idx_lt_cnt = (idx_reg < count_reg);
        stat.ins_go     = (sel_ent.deadline < when_reg);
        stat.match      = (sel_ent.handler == hnd_reg) && (sel_ent.tag == tag_reg);
        stat.exp_due    = (exp_n_reg < stq_pkg::EXP_W'(stq_pkg::MAX_EXPIRE))
                          && (count_reg != '0) && (ent_reg[0].deadline <= sec_reg);
        stat.exp_last   = (exp_n_reg == stq_pkg::EXP_W'(stq_pkg::MAX_EXPIRE - 1))
                          || (count_reg == stq_pkg::CNT_W'(1))
                          || (ent_reg[1].deadline > sec_reg);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= stq_pkg::CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.do_insert |-> count_reg < stq_pkg::CNT_W'(DEPTH))
        else $error("insert into a full queue");

    a_drop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.do_drop |=> count_reg == $past(count_reg) - stq_pkg::CNT_W'(1))
        else $error("delete did not lower the count by one");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> stat.out_free)
        else $error("result register loaded while still occupied");

endmodule

// ----- rtl/core/stq_ctrl.sv -----
// ============================================================================
// stq_ctrl: sequencing state machine of the sorted timeout queue
// Accepts one item at a time and steps the datapath through scan, shift
// and result phases.
// ============================================================================
module stq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  stq_pkg::dp_stat_t  stat,
    output stq_pkg::dp_cmd_t   ctl
);

    stq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            stq_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ctl.load   = 1'b1;
                    state_next = stq_pkg::ST_DISPATCH;
                end
            end
            stq_pkg::ST_DISPATCH: begin
                ctl.scan_clr = 1'b1;
                unique case (stat.cmd)
                    stq_pkg::CMD_TICK: begin
                        state_next = stat.wrap ? stq_pkg::ST_EXPIRE : stq_pkg::ST_IDLE;
                    end
                    stq_pkg::CMD_INSTALL: begin
                        state_next = stat.full ? stq_pkg::ST_RESP : stq_pkg::ST_INS_SCAN;
                    end
                    stq_pkg::CMD_REMOVE: begin
                        state_next = stq_pkg::ST_REM_SCAN;
                    end
                    default: begin
                        state_next = stq_pkg::ST_IDLE;
                    end
                endcase
            end
            stq_pkg::ST_INS_SCAN: begin
                if (stat.idx_lt_cnt && stat.ins_go) begin
                    ctl.scan_inc = 1'b1;
                end else if (stat.out_free) begin
                    ctl.do_insert = 1'b1;
                    ctl.out_load  = 1'b1;
                    ctl.out_kind  = stq_pkg::KIND_INSTALLED;
                    ctl.out_last  = 1'b1;
                    state_next    = stq_pkg::ST_IDLE;
                end
            end
            stq_pkg::ST_REM_SCAN: begin
                if (stat.idx_lt_cnt) begin
                    if (stat.match) begin
                        ctl.do_drop = 1'b1;
                    end else begin
                        ctl.scan_inc = 1'b1;
                    end
                end else begin
                    state_next = stq_pkg::ST_RESP;
                end
            end
            stq_pkg::ST_RESP: begin
                if (stat.out_free) begin
                    ctl.out_load = 1'b1;
                    ctl.out_last = 1'b1;
                    ctl.out_kind = (stat.cmd == stq_pkg::CMD_INSTALL) ?
                                   stq_pkg::KIND_FULL : stq_pkg::KIND_REMOVED;
                    state_next   = stq_pkg::ST_IDLE;
                end
            end
            stq_pkg::ST_EXPIRE: begin
                if (stat.exp_due) begin
                    if (stat.out_free) begin
                        ctl.out_load = 1'b1;
                        ctl.out_kind = stq_pkg::KIND_EXPIRED;
                        ctl.out_last = stat.exp_last;
                        ctl.do_drop  = 1'b1;
                        ctl.exp_inc  = 1'b1;
                    end
                end else begin
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load |=> state_reg == stq_pkg::ST_DISPATCH)
        else $error("accepted item did not move to dispatch");

    a_one_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.do_insert && ctl.do_drop))
        else $error("insert and delete in the same cycle");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.out_load && ctl.out_last) |=> state_reg == stq_pkg::ST_IDLE
        || state_reg == stq_pkg::ST_EXPIRE)
        else $error("final result not followed by idle or expiry end");

endmodule

// ----- rtl/core/sorted_timeout_queue_unit.sv -----
// ============================================================================
// sorted_timeout_queue_unit: sorted timeout queue with a tick prescaler
// Keeps pending timeouts ordered by deadline second; install, remove and
// tick items insert, delete and expire entries.
// ============================================================================
// Flow: an accepted item is dispatched; an install then scans the entries ahead
// of it, a remove scans every entry held, and a finished second expires due
// entries from the head. A refused install goes from dispatch to the response.
// Items are taken one at a time, each only once the last one is done.
// Reset (aresetn low at a clock edge) empties the queue, zeroes the seconds
// counter and loads 50 into the rate register and the prescaler.
// ============================================================================
module sorted_timeout_queue_unit (
    input  logic          aclk,
    input  logic          aresetn,

    // Rate register write port: ticks per second.
    input  logic          cfg_wen,
    input  logic [6:0]    cfg_wdata,

    // Input items.
    input  logic          s_tvalid,
    output logic          s_tready,
    // s_tdata, from bit 0: handler_id[15:0], arg_tag[47:16], offset_seconds[63:48]
    input  logic [63:0]   s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [1:0]    s_tuser,

    // Result items.
    output logic          m_tvalid,
    input  logic          m_tready,
    // m_tdata, from bit 0: out_handler[15:0], out_tag[47:16],
    // removed_count[52:48], now_seconds[84:53], zero fill[87:85]
    output logic [87:0]   m_tdata,
    // m_tuser: kind[1:0]
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);

    stq_pkg::dp_cmd_t  ctl;
    stq_pkg::dp_stat_t stat;

    logic [stq_pkg::HND_W-1:0]  out_handler;
    logic [stq_pkg::TAG_W-1:0]  out_tag;
    logic [stq_pkg::RCNT_W-1:0] out_count;
    logic [stq_pkg::SEC_W-1:0]  out_now;

    // The controller only takes a new item from its idle state; the result
    // register inside the datapath lets a result wait while the next item
    // is already being accepted.
    stq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    stq_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .in_cmd      (s_tuser),
        .in_handler  (s_tdata[15:0]),
        .in_tag      (s_tdata[47:16]),
        .in_offset   (s_tdata[63:48]),
        .ctl         (ctl),
        .stat        (stat),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_kind    (m_tuser),
        .out_handler (out_handler),
        .out_tag     (out_tag),
        .out_count   (out_count),
        .out_now     (out_now),
        .out_last    (m_tlast)
    );

    // Pack the result fields, lowest field first, zero filled to bytes.
    assign m_tdata = {3'b000, out_now, out_count, out_tag, out_handler};

endmodule
